// ===== design/dpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsc_pkg
// Types and constants for the dual-motor speed PID controller.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  // EMA weight of the new sample, Q0.16
  localparam logic [31:0] EMA_ALPHA = 32'd19661;

  // Width of the configuration write data and register index
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SPIKE_W    = 23;
  localparam int unsigned IVL_W      = 10;

  localparam logic [SPIKE_W-1:0] SPIKE_RESET = 23'h7FFFFF;
  localparam logic [IVL_W-1:0]   IVL_RESET   = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_A   = 3'd0,
    REG_INTEG_A  = 3'd1,
    REG_DERIV_A  = 3'd2,
    REG_PROP_B   = 3'd3,
    REG_INTEG_B  = 3'd4,
    REG_DERIV_B  = 3'd5,
    REG_SPIKE    = 3'd6,
    REG_INTERVAL = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPIKE,
    ST_EMA,
    ST_SMOOTH,
    ST_ERR,
    ST_INTM,
    ST_INTA,
    ST_PM,
    ST_IL,
    ST_IH,
    ST_IADD,
    ST_DM,
    ST_DINIT,
    ST_DDIV,
    ST_DADD,
    ST_FIN
  } state_e;

endpackage

// ===== design/dual_pid_speed_controller.sv =====
// ----------------------------------------------------------------------------
// dual_pid_speed_controller
// Two-motor speed PID with spike rejection, EMA smoothing and error deadband.
// Motor A is processed, then motor B; the shared 33x32 multiplier runs EMA,
// integral, P, I and D, and the D term divides by the interval with a
// restoring division over SPEED_WIDTH+17 quotient bits per motor. A new
// transaction is taken only when idle, after motor B has finished and the
// previous result is no longer stalled at the output.
// Reset clears gains, smoothed speeds, last errors and integrals; the spike
// limit resets to its maximum and the interval to 10 ms.
// ----------------------------------------------------------------------------
module dual_pid_speed_controller #(
  parameter int unsigned SPEED_WIDTH    = 24,
  parameter int unsigned FRACTION_BITS  = 8,
  parameter int unsigned INTEGRAL_WIDTH = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SPEED_WIDTH-1:0]   target_a_i,
  input  logic signed [SPEED_WIDTH-1:0]   measured_a_i,
  input  logic signed [SPEED_WIDTH-1:0]   target_b_i,
  input  logic signed [SPEED_WIDTH-1:0]   measured_b_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SPEED_WIDTH-1:0]   drive_a_o,
  output logic signed [SPEED_WIDTH-1:0]   drive_b_o
);
  import dpsc_pkg::*;

  localparam int unsigned SW   = SPEED_WIDTH;
  localparam int unsigned IW   = INTEGRAL_WIDTH;
  localparam int unsigned QW   = SW + 17;
  localparam int unsigned CW   = $clog2(QW + 1);
  localparam int unsigned ACCW = 53;
  localparam int unsigned ISW  = (IW > 42) ? IW + 2 : 44;
  localparam int unsigned CMPW = (SW + 1 > SPIKE_W) ? SW + 1 : SPIKE_W;
  localparam int unsigned EW   = 50;

  // ---------------- configuration ----------------
  logic [31:0]         kp_q [2];
  logic [31:0]         ki_q [2];
  logic [31:0]         kd_q [2];
  logic [SPIKE_W-1:0]  spike_q;
  logic [IVL_W-1:0]    tick_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q[0] <= '0; kp_q[1] <= '0;
      ki_q[0] <= '0; ki_q[1] <= '0;
      kd_q[0] <= '0; kd_q[1] <= '0;
      spike_q <= SPIKE_RESET;
      tick_q  <= IVL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_PROP_A:   kp_q[0] <= cfg_data_i;
        REG_INTEG_A:  ki_q[0] <= cfg_data_i;
        REG_DERIV_A:  kd_q[0] <= cfg_data_i;
        REG_PROP_B:   kp_q[1] <= cfg_data_i;
        REG_INTEG_B:  ki_q[1] <= cfg_data_i;
        REG_DERIV_B:  kd_q[1] <= cfg_data_i;
        REG_SPIKE:    spike_q <= cfg_data_i[SPIKE_W-1:0];
        REG_INTERVAL: tick_q  <= cfg_data_i[IVL_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  state_e state_q, state_d;
  logic   motor_q;
  logic   in_acc, out_acc;
  logic   div_done;
  logic   out_free;

  logic signed [SW-1:0]   tgt_q [2];
  logic signed [SW-1:0]   meas_q [2];
  logic [IVL_W-1:0]       ivl_q;
  logic signed [SW-1:0]   sm_q [2];
  logic signed [SW-1:0]   le_q [2];
  logic signed [IW-1:0]   ig_q [2];
  logic signed [SW:0]     dq_q;
  logic signed [SW-1:0]   err_q;
  logic [64:0]            prod_q;
  logic [47:0]            ilo_q;
  logic                   dneg_q;
  logic [QW-1:0]          dvd_q;
  logic [IVL_W-1:0]       rem_q;
  logic [CW-1:0]          cnt_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [SW-1:0]   da_q;
  logic                   out_valid_q;
  logic signed [SW-1:0]   drive_a_q, drive_b_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_done = (cnt_q == CW'(QW - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SPIKE;
      ST_SPIKE:  state_d = ST_EMA;
      ST_EMA:    state_d = ST_SMOOTH;
      ST_SMOOTH: state_d = ST_ERR;
      ST_ERR:    state_d = ST_INTM;
      ST_INTM:   state_d = ST_INTA;
      ST_INTA:   state_d = ST_PM;
      ST_PM:     state_d = ST_IL;
      ST_IL:     state_d = ST_IH;
      ST_IH:     state_d = ST_IADD;
      ST_IADD:   state_d = ST_DM;
      ST_DM:     state_d = ST_DINIT;
      ST_DINIT:  state_d = ST_DDIV;
      ST_DDIV:   if (div_done) state_d = ST_DADD;
      ST_DADD:   state_d = ST_FIN;
      ST_FIN: begin
        if (!motor_q) state_d = ST_SPIKE;
        else if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- shared multiplier operands ----------------
  logic [32:0]          mul_a;
  logic [31:0]          mul_b;
  logic [64:0]          mul_p;
  logic [63:0]          igm;
  logic signed [SW:0]   ediff;
  logic [SW:0]          dq_mag, ediff_mag;
  logic [SW-1:0]        err_mag;

  assign igm       = ig_q[motor_q][IW-1] ? -64'(ig_q[motor_q]) : 64'(ig_q[motor_q]);
  assign dq_mag    = dq_q[SW] ? -dq_q : dq_q;
  assign err_mag   = err_q[SW-1] ? -err_q : err_q;
  assign ediff     = $signed({err_q[SW-1], err_q}) - $signed({le_q[motor_q][SW-1], le_q[motor_q]});
  assign ediff_mag = ediff[SW] ? -ediff : ediff;

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_EMA:  begin mul_a = 33'(dq_mag);        mul_b = EMA_ALPHA;          end
      ST_INTM: begin mul_a = 33'(err_mag);       mul_b = 32'(ivl_q);         end
      ST_PM:   begin mul_a = 33'(err_mag);       mul_b = kp_q[motor_q];      end
      ST_IL:   begin mul_a = {1'b0, igm[31:0]};  mul_b = ki_q[motor_q];      end
      ST_IH:   begin mul_a = {1'b0, igm[63:32]}; mul_b = ki_q[motor_q];      end
      ST_DM:   begin mul_a = 33'(ediff_mag);     mul_b = kd_q[motor_q];      end
      default: ;
    endcase
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // ---------------- datapath ----------------
  logic signed [SW:0]      spk_diff;
  logic [SW:0]             spk_mag;
  logic                    spk_hit;
  logic signed [EW-1:0]    ema_ps, ema_t, ema_s;
  logic signed [SW-1:0]    s_sat;
  logic signed [SW:0]      e_full;
  logic signed [SW-1:0]    e_sat;
  logic [SW-1:0]           e_mag;
  logic signed [ISW-1:0]   isum, iprod;
  logic signed [IW-1:0]    i_sat;
  logic [63:0]             ir;
  logic [50:0]             ir_cap;
  logic [IVL_W:0]          div_r2;
  logic                    div_bit;
  logic signed [ACCW-1:0]  acc_d;
  logic signed [SW-1:0]    acc_sat;
  logic [ACCW-2:0]         term_mag;
  logic                    term_neg;

  assign spk_diff = $signed({meas_q[motor_q][SW-1], meas_q[motor_q]})
                  - $signed({sm_q[motor_q][SW-1], sm_q[motor_q]});
  assign spk_mag  = spk_diff[SW] ? -spk_diff : spk_diff;
  assign spk_hit  = CMPW'(spk_mag) > CMPW'(spike_q);

  // round half up of alpha*delta / 2^16, added back onto the old value
  assign ema_ps = dq_q[SW] ? -$signed({2'b00, prod_q[47:0]}) : $signed({2'b00, prod_q[47:0]});
  assign ema_t  = (ema_ps + EW'(32768)) >>> 16;
  assign ema_s  = ema_t + EW'(sm_q[motor_q]);
  always_comb begin
    if (ema_s > EW'(2 ** (SW - 1) - 1))       s_sat = {1'b0, {(SW-1){1'b1}}};
    else if (ema_s < -EW'(2 ** (SW - 1)))     s_sat = {1'b1, {(SW-1){1'b0}}};
    else                                      s_sat = ema_s[SW-1:0];
  end

  assign e_full = $signed({tgt_q[motor_q][SW-1], tgt_q[motor_q]})
                - $signed({sm_q[motor_q][SW-1], sm_q[motor_q]});
  always_comb begin
    if (e_full[SW] != e_full[SW-1]) e_sat = {e_full[SW], {(SW-1){!e_full[SW]}}};
    else                            e_sat = e_full[SW-1:0];
  end
  assign e_mag = e_sat[SW-1] ? -e_sat : e_sat;

  assign iprod = err_q[SW-1] ? -$signed(ISW'(prod_q[41:0])) : $signed(ISW'(prod_q[41:0]));
  assign isum  = ISW'(ig_q[motor_q]) + iprod;
  always_comb begin
    if (isum > ISW'(2 ** (IW - 1) - 1))       i_sat = {1'b0, {(IW-1){1'b1}}};
    else if (isum < -ISW'(2 ** (IW - 1)))     i_sat = {1'b1, {(IW-1){1'b0}}};
    else                                      i_sat = isum[IW-1:0];
  end

  // integral term: (hi*g << 16) + (lo*g >> 16), capped at 2^50
  assign ir     = {prod_q[47:0], 16'h0} + 64'(ilo_q);
  assign ir_cap = (ir > 64'(2) ** 50) ? {1'b1, 50'h0} : ir[50:0];

  assign div_r2  = {rem_q, dvd_q[QW-1]};
  assign div_bit = div_r2 >= (IVL_W+1)'(ivl_q);

  always_comb begin
    term_mag = '0;
    term_neg = 1'b0;
    unique case (state_q)
      ST_IL:   begin term_mag = (ACCW-1)'(prod_q[63:16]); term_neg = err_q[SW-1];     end
      ST_IADD: begin term_mag = (ACCW-1)'(ir_cap);        term_neg = ig_q[motor_q][IW-1]; end
      ST_DADD: begin term_mag = (ACCW-1)'(dvd_q);         term_neg = dneg_q;          end
      default: ;
    endcase
  end

  assign acc_d = acc_q + (term_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag}));

  always_comb begin
    if (acc_q > ACCW'(2 ** (SW - 1) - 1))     acc_sat = {1'b0, {(SW-1){1'b1}}};
    else if (acc_q < -ACCW'(2 ** (SW - 1)))   acc_sat = {1'b1, {(SW-1){1'b0}}};
    else                                      acc_sat = acc_q[SW-1:0];
  end

  // raise the result at the final step of motor B, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && motor_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      motor_q     <= 1'b0;
      cnt_q       <= '0;
      ivl_q       <= 10'd1;
      sm_q[0] <= '0; sm_q[1] <= '0;
      le_q[0] <= '0; le_q[1] <= '0;
      ig_q[0] <= '0; ig_q[1] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            tgt_q[0]  <= target_a_i;
            meas_q[0] <= measured_a_i;
            tgt_q[1]  <= target_b_i;
            meas_q[1] <= measured_b_i;
            ivl_q     <= (tick_q == '0) ? IVL_W'(1) : tick_q;
            motor_q   <= 1'b0;
          end
        end
        ST_SPIKE:  dq_q <= spk_hit ? '0 : spk_diff;
        ST_EMA:    prod_q <= mul_p;
        ST_SMOOTH: sm_q[motor_q] <= s_sat;
        ST_ERR:    err_q <= (e_mag < SW'(2 ** FRACTION_BITS)) ? '0 : e_sat;
        ST_INTM:   prod_q <= mul_p;
        ST_INTA:   ig_q[motor_q] <= i_sat;
        ST_PM: begin
          prod_q <= mul_p;
          acc_q  <= '0;
        end
        ST_IL: begin
          acc_q  <= acc_d;
          prod_q <= mul_p;
        end
        ST_IH: begin
          ilo_q  <= prod_q[63:16];
          prod_q <= mul_p;
        end
        ST_IADD:   acc_q <= acc_d;
        ST_DM: begin
          prod_q <= mul_p;
          dneg_q <= ediff[SW];
        end
        ST_DINIT: begin
          dvd_q <= prod_q[SW+32:16];
          rem_q <= '0;
          cnt_q <= '0;
        end
        ST_DDIV: begin
          // restoring division, quotient shifts into the dividend register
          rem_q <= div_bit ? IVL_W'(div_r2 - (IVL_W+1)'(ivl_q)) : div_r2[IVL_W-1:0];
          dvd_q <= {dvd_q[QW-2:0], div_bit};
          cnt_q <= cnt_q + CW'(1);
        end
        ST_DADD:   acc_q <= acc_d;
        ST_FIN: begin
          if (!motor_q) begin
            le_q[0] <= err_q;
            da_q    <= acc_sat;
            motor_q <= 1'b1;
          end else if (out_free) begin
            le_q[1]     <= err_q;
            drive_a_q   <= da_q;
            drive_b_q   <= acc_sat;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_a_o   = drive_a_q;
  assign drive_b_o   = drive_b_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after accepting a transaction");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN) && $past(motor_q))
    else $error("result raised outside the final step of motor B");

  a_interval_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (ivl_q != '0))
    else $error("zero divisor while busy");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DDIV) |-> (cnt_q < CW'(QW)) && (rem_q < ivl_q))
    else $error("divider step out of range");

endmodule

// ===== tb/dual_pid_speed_controller_test.sv =====
// ----------------------------------------------------------------------------
// dual_pid_speed_controller_test
// Self-checking bench for the two-motor speed PID controller. A queue-fed
// driver sends control ticks while the configuration is changed between
// phases. A predictor computes the expected drive pair for every
// accepted tick. The monitor compares each result with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_pid_speed_controller_test;
  import dpsc_pkg::*;

  localparam int SW          = 24;
  localparam int FB          = 8;
  localparam int IW          = 40;
  localparam int TICK_LAT    = 160;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [SW-1:0] target_a;
    logic signed [SW-1:0] measured_a;
    logic signed [SW-1:0] target_b;
    logic signed [SW-1:0] measured_b;
  } tick_t;

  typedef struct {
    logic signed [SW-1:0] drive_a;
    logic signed [SW-1:0] drive_b;
  } drive_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SW-1:0] target_a_i = '0;
  logic signed [SW-1:0] measured_a_i = '0;
  logic signed [SW-1:0] target_b_i = '0;
  logic signed [SW-1:0] measured_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SW-1:0] drive_a_o;
  logic signed [SW-1:0] drive_b_o;

  dual_pid_speed_controller dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor copy of configuration and per-motor state
  logic [31:0] gain_q[2][3];
  logic [SPIKE_W-1:0] spike_lim;
  logic [IVL_W-1:0] interval_ms;
  longint smooth_spd[2];
  longint prev_err[2];
  longint err_accum[2];

  tick_t pending_ticks[$];
  drive_pair_t expected_drives[$];
  int idle_pct = 28;
  int stall_pct = 28;
  int ticks_sent = 0;
  int drives_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic void add_tick(tick_t t);
    pending_ticks.insert(pending_ticks.size(), t);
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // sign(x) * min(floor(|x| * g / 2^16), 2^50)
  function automatic longint gain_mult(longint x, logic [31:0] g);
    longint unsigned m;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    m = absval(x);
    hi = (m >> 32) * longint'(g);
    lo = (m & 64'hFFFF_FFFF) * longint'(g);
    r = (hi << 16) + (lo >> 16);
    if (r > (64'd1 << 50)) r = 64'd1 << 50;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint motor_drive(int k, longint tgt, longint meas, longint ivl);
    longint prior;
    longint err;
    longint diff;
    longint p_term;
    longint i_term;
    longint d_term;
    longint unsigned dm;
    prior = smooth_spd[k];
    // reject spikes: reuse the stored filtered speed
    if (absval(meas - prior) > longint'(spike_lim)) meas = prior;
    smooth_spd[k] = clamp((longint'(EMA_ALPHA) * meas
                           + longint'(65536 - EMA_ALPHA) * prior + 32768) >>> 16, SW);
    err = clamp(tgt - smooth_spd[k], SW);
    if (absval(err) < (64'd1 << FB)) err = 0;
    err_accum[k] = clamp(err_accum[k] + err * ivl, IW);
    p_term = gain_mult(err, gain_q[k][0]);
    i_term = gain_mult(err_accum[k], gain_q[k][1]);
    diff = err - prev_err[k];
    dm = (absval(diff) * longint'(gain_q[k][2])) / longint'(ivl << 16);
    d_term = (diff < 0) ? -longint'(dm) : longint'(dm);
    prev_err[k] = err;
    return clamp(p_term + i_term + d_term, SW);
  endfunction

  function automatic drive_pair_t predict_drives(tick_t t);
    drive_pair_t d;
    longint ivl;
    ivl = (interval_ms == 0) ? 1 : longint'(interval_ms);
    d.drive_a = SW'(motor_drive(0, longint'(t.target_a), longint'(t.measured_a), ivl));
    d.drive_b = SW'(motor_drive(1, longint'(t.target_b), longint'(t.measured_b), ivl));
    return d;
  endfunction

  // driver: advance to the next pending tick once the current one is taken
  always @(posedge clk_i) begin
    tick_t t;
    tick_t sent;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sent.target_a   = target_a_i;
        sent.measured_a = measured_a_i;
        sent.target_b   = target_b_i;
        sent.measured_b = measured_b_i;
        expected_drives.insert(expected_drives.size(), predict_drives(sent));
        ticks_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= idle_pct) begin
          t = pending_ticks[0];
          pending_ticks.delete(0);
          target_a_i   <= t.target_a;
          measured_a_i <= t.measured_a;
          target_b_i   <= t.target_b;
          measured_b_i <= t.measured_b;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each transaction against the oldest expectation
  always @(posedge clk_i) begin
    drive_pair_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result a=%0d b=%0d", drive_a_o, drive_b_o);
        end else begin
          e = expected_drives[0];
          expected_drives.delete(0);
          if (drive_a_o !== e.drive_a || drive_b_o !== e.drive_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d drive_a exp %0d got %0d, drive_b exp %0d got %0d",
                       drives_seen, e.drive_a, drive_a_o, e.drive_b, drive_b_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: count cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SPIKE:    spike_lim = val[SPIKE_W-1:0];
      REG_INTERVAL: interval_ms = val[IVL_W-1:0];
      default:      gain_q[int'(idx) / 3][int'(idx) % 3] = val;
    endcase
  endtask

  // hold until every expected drive pair has come, then let the block settle
  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid_i || expected_drives.size() > 0)
      @(posedge clk_i);
    repeat (TICK_LAT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_gain(int sel);
    case (sel)
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom_range(32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [SW-1:0] rand_speed(bit wide);
    return wide ? SW'($urandom) : SW'($signed($urandom_range(32'h1_0000)) - 32'sh8000);
  endfunction

  task automatic queue_random(int n);
    tick_t t;
    repeat (n) begin
      if ($urandom_range(99) < 75) begin
        // plausible operation: measured speed close to target
        t.target_a   = rand_speed(0);
        t.target_b   = rand_speed(0);
        t.measured_a = t.target_a + SW'($signed($urandom_range(2048)) - 1024);
        t.measured_b = t.target_b + SW'($signed($urandom_range(2048)) - 1024);
      end else begin
        t.target_a   = rand_speed(1);
        t.measured_a = rand_speed(1);
        t.target_b   = rand_speed(1);
        t.measured_b = rand_speed(1);
      end
      add_tick(t);
    end
  endtask

  localparam logic signed [SW-1:0] SPD_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SPD_MIN = {1'b1, {(SW-1){1'b0}}};

  initial begin
    for (int k = 0; k < 2; k++) begin
      smooth_spd[k] = 0;
      prev_err[k] = 0;
      err_accum[k] = 0;
      for (int j = 0; j < 3; j++) gain_q[k][j] = '0;
    end
    spike_lim = SPIKE_RESET;
    interval_ms = IVL_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, deadband edges, spike rejection, zero interval
    write_reg(REG_PROP_A, 32'h0001_0000);
    write_reg(REG_INTEG_A, 32'h0000_0100);
    write_reg(REG_DERIV_A, 32'h0002_0000);
    write_reg(REG_PROP_B, 32'hFFFF_FFFF);
    write_reg(REG_INTEG_B, 32'hFFFF_FFFF);
    write_reg(REG_DERIV_B, 32'hFFFF_FFFF);
    add_tick('{SPD_MAX, SPD_MAX, SPD_MIN, SPD_MIN});
    add_tick('{SPD_MIN, SPD_MAX, SPD_MAX, SPD_MIN});
    add_tick('{24'sd255, 24'sd0, -24'sd255, 24'sd0});
    add_tick('{24'sd256, 24'sd0, -24'sd256, 24'sd0});
    add_tick('{24'sd0, 24'sd0, 24'sd0, 24'sd0});
    add_tick('{SPD_MAX, SPD_MIN, SPD_MIN, SPD_MAX});
    add_tick('{-24'sd1, -24'sd1, 24'sd1, 24'sd1});
    drain();
    write_reg(REG_SPIKE, 23'd0);
    write_reg(REG_INTERVAL, 10'd0);
    add_tick('{24'sd5000, 24'sd4000, -24'sd5000, -24'sd4000});
    add_tick('{SPD_MAX, SPD_MAX, SPD_MIN, SPD_MIN});
    add_tick('{24'sd0, 24'sd0, 24'sd0, 24'sd0});
    drain();
    write_reg(REG_SPIKE, 23'd1024);
    write_reg(REG_INTERVAL, 10'd1023);
    add_tick('{24'sd3000, 24'sd1000, 24'sd3000, 24'sd900});
    add_tick('{24'sd3000, 24'sd2000, 24'sd3000, 24'sd5000});
    add_tick('{SPD_MIN, SPD_MIN, SPD_MAX, SPD_MAX});
    drain();

    // random phases with changing configuration
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PROP_A, pick_gain($urandom_range(4)));
      write_reg(REG_INTEG_A, pick_gain($urandom_range(4)));
      write_reg(REG_DERIV_A, pick_gain($urandom_range(4)));
      write_reg(REG_PROP_B, pick_gain($urandom_range(4)));
      write_reg(REG_INTEG_B, pick_gain($urandom_range(4)));
      write_reg(REG_DERIV_B, pick_gain($urandom_range(4)));
      case (ph % 4)
        0: write_reg(REG_SPIKE, 23'h7FFFFF);
        1: write_reg(REG_SPIKE, 23'd0);
        default: write_reg(REG_SPIKE, $urandom_range(4096));
      endcase
      case (ph % 4)
        0: write_reg(REG_INTERVAL, 10'd1);
        1: write_reg(REG_INTERVAL, 10'd1000);
        2: write_reg(REG_INTERVAL, 10'd0);
        default: write_reg(REG_INTERVAL, $urandom_range(1, 1000));
      endcase
      // one phase runs with no idling on either side
      idle_pct = (ph == 3) ? 0 : 28;
      stall_pct = (ph == 3) ? 0 : 28;
      queue_random(150);
      drain();
    end

    $display("Ran %0d control ticks over 11 configuration phases, %0d results checked.",
             ticks_sent, drives_seen);
    $display("Covered gain, spike limit and interval extremes including zero interval.");
    if (mismatches == 0 && !timed_out) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== dual_pid_speed_controller.f =====
design/dpsc_pkg.sv
design/dual_pid_speed_controller.sv
tb/dual_pid_speed_controller_test.sv
